/* rtl/mlrr_pkg.sv */
package mlrr_pkg;

    localparam int MAX_ENTRIES_DEF = 64;
    localparam int NUM_LEVELS_DEF  = 4;
    localparam int ID_BITS_DEF     = 16;

    // request kinds
    localparam logic [1:0] REQ_ADD    = 2'd0;
    localparam logic [1:0] REQ_REMOVE = 2'd1;
    localparam logic [1:0] REQ_NEXT   = 2'd2;
    localparam logic [1:0] REQ_RSVD   = 2'd3;   // unused code, answered with no effect

    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 24;

endpackage

/* rtl/mlrr_ram.sv */
module mlrr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

/* rtl/multilevel_round_robin_scheduler.sv */
// Multilevel round-robin scheduler: NUM_LEVELS FIFO lists of process ids share a pool of
// MAX_ENTRIES entries held in one synchronous RAM (id, next link, prev link per entry), with
// the used bit of each entry in a second one-bit RAM. After reset a clearing pass over all
// MAX_ENTRIES entries zeroes the used bits; s_axis_tready stays low until it ends. Requests
// arrive on the s_axis port, one result per request leaves on m_axis. An add takes the
// lowest free entry (found by a scan of the used bits, a read and a check per entry) and
// appends it. A remove walks the lists level by level, head to tail, one RAM read per entry,
// skipping empty levels. A next grants the head of the current level; when the granted
// process is not alone in its level it is rotated: unlinked and appended again at the tail.
// Every link read and link write goes through the one-read one-write entry RAM. The list
// heads and tails reset in flip-flops. A new request is taken only in the idle state while
// the output register is empty or being drained.
module multilevel_round_robin_scheduler #(
    parameter int MAX_ENTRIES = mlrr_pkg::MAX_ENTRIES_DEF,
    parameter int NUM_LEVELS  = mlrr_pkg::NUM_LEVELS_DEF,
    parameter int ID_BITS     = mlrr_pkg::ID_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [1:0] req_type, [17:2] proc_id, [20:18] prio_level, zero fill
    input  logic [mlrr_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [15:0] granted_id, [16] success, [19:17] time_quantum, [20] any_waiting, zero fill
    output logic [mlrr_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

    localparam int AW = $clog2(MAX_ENTRIES);
    localparam int LW = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
    localparam int PW = AW + 1;                 // link width, empty marker = MAX_ENTRIES
    localparam int RW = ID_BITS + 2 * PW;       // ram word: id, next, prev
    localparam logic [PW-1:0] EMPTY = PW'(MAX_ENTRIES);

    // sequencer states
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SCAN   = 4'd1;   // add: read used bit
    localparam logic [3:0] S_APPW   = 4'd2;   // write own word
    localparam logic [3:0] S_TAILR  = 4'd3;   // read old tail
    localparam logic [3:0] S_TAILW  = 4'd4;   // write old tail next
    localparam logic [3:0] S_WALKR  = 4'd5;   // remove: read cur
    localparam logic [3:0] S_WALKC  = 4'd6;   // compare
    localparam logic [3:0] S_PREVR  = 4'd7;   // unlink: read prev
    localparam logic [3:0] S_PREVW  = 4'd8;
    localparam logic [3:0] S_NXTR   = 4'd9;   // unlink: read next
    localparam logic [3:0] S_NXTW   = 4'd10;
    localparam logic [3:0] S_DONE   = 4'd11;
    localparam logic [3:0] S_HEADR  = 4'd12;  // next: read head
    localparam logic [3:0] S_HEADC  = 4'd13;
    localparam logic [3:0] S_SCANC  = 4'd14;  // add: check used bit
    localparam logic [3:0] S_CLR    = 4'd15;  // clearing pass after reset

    logic [3:0]           r_state, n_state;
    logic [PW-1:0]        r_head [NUM_LEVELS];
    logic [PW-1:0]        r_tail [NUM_LEVELS];
    logic [LW-1:0]        r_lptr;
    logic [AW-1:0]        r_clr;        // clearing pass address
    logic [1:0]           r_req;
    logic [ID_BITS-1:0]   r_id;
    logic [LW-1:0]        r_lvl;
    logic [AW-1:0]        r_slot;       // entry under work
    logic [AW:0]          r_cnt;        // scan count
    logic [RW-1:0]        r_word;       // captured word of r_slot
    logic                 r_rot;        // unlink is part of a rotate
    logic                 r_ovalid;
    logic [23:0]          r_odata;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr, ram_raddr;
    logic [RW-1:0]        ram_wdata, ram_rdata;

    logic                 used_we;
    logic [AW-1:0]        used_waddr, used_raddr;
    logic                 used_wdata, used_rdata;

    mlrr_ram #(.WIDTH(RW), .DEPTH(MAX_ENTRIES)) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    // one used bit per entry
    mlrr_ram #(.WIDTH(1), .DEPTH(MAX_ENTRIES)) u_used (
        .i_clk  (i_clk),
        .i_we   (used_we),
        .i_waddr(used_waddr),
        .i_wdata(used_wdata),
        .i_raddr(used_raddr),
        .o_rdata(used_rdata)
    );

    // word fields
    logic [ID_BITS-1:0] rd_id;
    logic [PW-1:0]      rd_next, rd_prev, w_next, w_prev;
    assign rd_id   = ram_rdata[ID_BITS-1:0];
    assign rd_next = ram_rdata[ID_BITS +: PW];
    assign rd_prev = ram_rdata[ID_BITS+PW +: PW];
    assign w_next  = r_word[ID_BITS +: PW];
    assign w_prev  = r_word[ID_BITS+PW +: PW];

    logic any_wait;
    always_comb begin
        any_wait = 1'b0;
        for (int l = 0; l < NUM_LEVELS; l++) begin
            if (r_head[l] != EMPTY) begin
                any_wait = 1'b1;
            end
        end
    end

    // input fields
    logic [1:0]         in_req;
    logic [ID_BITS-1:0] in_id;
    logic [2:0]         in_prio;
    logic [31:0]        in_id_ext;
    assign in_req    = s_axis_tdata[1:0];
    assign in_id_ext = {16'd0, s_axis_tdata[17:2]};
    assign in_id     = in_id_ext[ID_BITS-1:0];
    assign in_prio   = s_axis_tdata[20:18];

    assign s_axis_tready = (r_state == S_IDLE) && (!r_ovalid || m_axis_tready);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

    logic          do_out;
    logic          o_ok;
    logic [31:0]   o_gid;
    logic [2:0]    o_q;
    logic          aw_after;

    // quantum for level r_lvl, saturated to 7
    logic [2:0] qv;
    always_comb begin
        if ((NUM_LEVELS - 32'(r_lvl)) > 7) begin
            qv = 3'd7;
        end else begin
            qv = 3'((NUM_LEVELS - 32'(r_lvl)));
        end
    end

    logic [LW-1:0] lvl_inc;
    always_comb begin
        if (32'(r_lvl) == NUM_LEVELS - 1) begin
            lvl_inc = '0;
        end else begin
            lvl_inc = r_lvl + LW'(1);
        end
    end

    logic [PW-1:0] slot_p;
    assign slot_p = {1'b0, r_slot};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_ovalid <= 1'b0;
            r_lptr   <= '0;
            r_clr    <= '0;
            for (int l = 0; l < NUM_LEVELS; l++) begin
                r_head[l] <= EMPTY;
                r_tail[l] <= EMPTY;
            end
        end else begin
            r_state <= n_state;
            if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            if (do_out) begin
                r_ovalid <= 1'b1;
            end
            // head/tail, clearing address and level pointer updates
            case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + 1'b1;
                end
                S_APPW: begin
                    r_tail[r_lvl] <= slot_p;
                    if (r_tail[r_lvl] == EMPTY) begin
                        r_head[r_lvl] <= slot_p;
                    end
                end
                S_PREVW: begin
                    if (w_prev == EMPTY) begin
                        r_head[r_lvl] <= w_next;
                    end
                end
                S_NXTW: begin
                    if (w_next == EMPTY) begin
                        r_tail[r_lvl] <= w_prev;
                    end
                end
                S_HEADC: begin
                    r_lptr <= lvl_inc;
                end
                default: begin
                end
            endcase
        end
    end

    // sequencer
    always_comb begin
        n_state    = r_state;
        do_out     = 1'b0;
        o_ok       = 1'b0;
        o_gid      = '0;
        o_q        = '0;
        aw_after   = any_wait;
        ram_we     = 1'b0;
        ram_waddr  = r_slot;
        ram_wdata  = r_word;
        ram_raddr  = r_slot;
        used_we    = 1'b0;
        used_waddr = r_slot;
        used_wdata = 1'b0;
        used_raddr = r_cnt[AW-1:0];
        case (r_state)
            S_CLR: begin
                used_we    = 1'b1;
                used_waddr = r_clr;
                if (r_clr == AW'(MAX_ENTRIES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_axis_tvalid && s_axis_tready) begin
                    if (in_req == mlrr_pkg::REQ_ADD) begin
                        if (in_prio >= 3'd1 && 32'(in_prio) <= NUM_LEVELS) begin
                            n_state = S_SCAN;
                        end else begin
                            do_out = 1'b1;
                        end
                    end else if (in_req == mlrr_pkg::REQ_REMOVE) begin
                        if (any_wait) begin
                            n_state = S_WALKR;
                        end else begin
                            do_out = 1'b1;
                        end
                    end else if (in_req == mlrr_pkg::REQ_NEXT) begin
                        if (any_wait) begin
                            n_state = S_HEADR;
                        end else begin
                            do_out = 1'b1;
                        end
                    end else begin
                        do_out = 1'b1;
                    end
                end
            end
            S_SCAN: begin
                // pool full once every entry has been checked
                if (r_cnt == (AW+1)'(MAX_ENTRIES)) begin
                    do_out  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_SCANC;
                end
            end
            S_SCANC: begin
                if (!used_rdata) begin
                    n_state = S_APPW;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_APPW: begin
                ram_we     = 1'b1;
                ram_wdata  = {r_tail[r_lvl], EMPTY, r_id};
                ram_raddr  = r_tail[r_lvl][AW-1:0];
                used_we    = 1'b1;
                used_wdata = 1'b1;
                if (r_tail[r_lvl] == EMPTY) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_TAILR;
                end
            end
            S_TAILR: begin
                ram_raddr = r_word[ID_BITS+PW +: AW];
                n_state   = S_TAILW;
            end
            S_TAILW: begin
                ram_we    = 1'b1;
                ram_waddr = r_word[ID_BITS+PW +: AW];
                ram_wdata = {rd_prev, slot_p, rd_id};
                n_state   = S_DONE;
            end
            S_WALKR: begin
                // skip empty levels, miss after the last one
                if (r_head[r_lvl] == EMPTY) begin
                    if (32'(r_lvl) == NUM_LEVELS - 1) begin
                        do_out  = 1'b1;
                        n_state = S_IDLE;
                    end
                end else begin
                    n_state = S_WALKC;
                end
            end
            S_WALKC: begin
                if (rd_id == r_id) begin
                    n_state = S_PREVR;
                end else if (rd_next == EMPTY && 32'(r_lvl) == NUM_LEVELS - 1) begin
                    // end of the last list, no match
                    do_out  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_WALKR;
                end
            end
            S_PREVR: begin
                ram_raddr = w_prev[AW-1:0];
                n_state   = S_PREVW;
            end
            S_PREVW: begin
                if (w_prev != EMPTY) begin
                    ram_we    = 1'b1;
                    ram_waddr = w_prev[AW-1:0];
                    ram_wdata = {rd_prev, w_next, rd_id};
                end
                n_state = S_NXTR;
            end
            S_NXTR: begin
                ram_raddr = w_next[AW-1:0];
                n_state   = S_NXTW;
            end
            S_NXTW: begin
                if (w_next != EMPTY) begin
                    ram_we    = 1'b1;
                    ram_waddr = w_next[AW-1:0];
                    ram_wdata = {w_prev, rd_next, rd_id};
                end
                if (r_rot) begin
                    n_state = S_APPW;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                do_out  = 1'b1;
                o_ok    = 1'b1;
                n_state = S_IDLE;
                if (r_req == mlrr_pkg::REQ_NEXT) begin
                    o_gid = 32'(r_id);
                    o_q   = qv;
                end
                if (r_req == mlrr_pkg::REQ_REMOVE) begin
                    // head/tail already updated, used bit clears this cycle
                    aw_after = any_wait;
                    used_we  = 1'b1;
                end
            end
            S_HEADR: begin
                ram_raddr = r_head[r_lvl][AW-1:0];
                if (r_head[r_lvl] != EMPTY) begin
                    n_state = S_HEADC;
                end
            end
            S_HEADC: begin
                if (r_head[r_lvl] == r_tail[r_lvl]) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_PREVR;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_req  <= in_req;
                r_id   <= in_id;
                r_cnt  <= '0;
                r_rot  <= 1'b0;
                r_lvl  <= LW'(in_prio - 3'd1);
                if (in_req == mlrr_pkg::REQ_NEXT) begin
                    r_lvl <= r_lptr;
                end else if (in_req == mlrr_pkg::REQ_REMOVE) begin
                    r_lvl  <= '0;
                    r_slot <= r_head[0][AW-1:0];
                end
            end
            S_SCANC: begin
                r_slot <= r_cnt[AW-1:0];
                r_cnt  <= r_cnt + 1'b1;
            end
            S_APPW: begin
                r_word <= {r_tail[r_lvl], EMPTY, r_id};
            end
            S_WALKR: begin
                // skip empty lists
                if (r_head[r_lvl] == EMPTY) begin
                    r_lvl  <= lvl_inc;
                    r_slot <= r_head[lvl_inc][AW-1:0];
                end
            end
            S_WALKC: begin
                r_word <= ram_rdata;
                if (rd_id != r_id) begin
                    if (rd_next != EMPTY) begin
                        r_slot <= rd_next[AW-1:0];
                    end else begin
                        r_lvl  <= lvl_inc;
                        r_slot <= r_head[lvl_inc][AW-1:0];
                    end
                end
            end
            S_HEADR: begin
                r_slot <= r_head[r_lvl][AW-1:0];
                if (r_head[r_lvl] == EMPTY) begin
                    r_lvl <= lvl_inc;
                end
            end
            S_HEADC: begin
                r_word <= ram_rdata;
                r_id   <= rd_id;
                r_rot  <= 1'b1;
            end
            default: begin
            end
        endcase
        if (do_out) begin
            r_odata <= {3'd0, aw_after, o_q, o_ok, o_gid[15:0]};
        end
    end

endmodule
